// ===== rtl/bmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmm_pkg
// shared constants and types of the bipartite matching block
// ---------------------------------------------------------------------------
package bmm_pkg;

    localparam int MAX_LEFT_DEF  = 32;
    localparam int MAX_RIGHT_DEF = 32;

    // width of every vertex and count field on the channels
    localparam int FW = 6;

    // register indexes
    localparam logic REG_NUM_LEFT  = 1'b0;
    localparam logic REG_NUM_RIGHT = 1'b1;

    localparam logic [FW-1:0] NUM_RESET = FW'(32);

    typedef struct packed {
        logic [FW-1:0] num_left;
        logic [FW-1:0] num_right;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/bmm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmm_in_if
// input channel: edge items and the end item
// ---------------------------------------------------------------------------
interface bmm_in_if;
    import bmm_pkg::*;

    logic          valid;
    logic          ready;
    logic          kind;
    logic [FW-1:0] left_vertex;
    logic [FW-1:0] right_vertex;

    modport source(output valid, output kind, output left_vertex, output right_vertex,
                   input ready);
    modport sink(input valid, input kind, input left_vertex, input right_vertex,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/bmm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmm_out_if
// result channel: matching size followed by matched pairs
// ---------------------------------------------------------------------------
interface bmm_out_if;
    import bmm_pkg::*;

    logic          valid;
    logic          ready;
    logic          is_count;
    logic [FW-1:0] match_count;
    logic [FW-1:0] pair_left;
    logic [FW-1:0] pair_right;
    logic          last;

    modport source(output valid, output is_count, output match_count, output pair_left,
                   output pair_right, output last, input ready);
    modport sink(input valid, input is_count, input match_count, input pair_left,
                 input pair_right, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bipartite_max_matching.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bipartite_max_matching
// maximum bipartite matching by augmenting paths over a stored edge bitmap
//
// i_in carries edge transactions (kind 0) and an end transaction (kind 1).
// An edge transaction with both vertices in range sets one adjacency bit.
// The end transaction starts the search; i_in stays not ready until the
// run is finished. Each search step reads the adjacency, match or stack
// memory through its registered read port: a left vertex starts with an
// adjacency read, a right vertex taken reads its match entry, a push writes
// a stack frame, a pop reads one back, and an augment reads each frame below
// the top and writes its match entry back. Afterwards the match memory is
// swept to count the matches and, if any, once more; o_out gives the count
// transaction and then one transaction per matched pair in increasing right
// order, last set on the final one. A stalled o_out holds the sequencer at
// the next result. After reset and after every run a clearing pass zeroes
// the adjacency and match memories while i_in is not ready. num_left and
// num_right lie on the apb port at byte addresses 0 and 4.
// ---------------------------------------------------------------------------
module bipartite_max_matching #(
    parameter int MAX_LEFT  = bmm_pkg::MAX_LEFT_DEF,
    parameter int MAX_RIGHT = bmm_pkg::MAX_RIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bmm_in_if.sink           i_in,
    bmm_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import bmm_pkg::*;

    t_cfg cfg;

    bmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bmm_engine #(
        .MAX_LEFT  (MAX_LEFT),
        .MAX_RIGHT (MAX_RIGHT)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire

// ===== rtl/bmm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmm_cfg
// apb register file holding the vertex counts
// ---------------------------------------------------------------------------
module bmm_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output bmm_pkg::t_cfg      o_cfg
);
    import bmm_pkg::*;

    logic [FW-1:0] r_num_left;
    logic [FW-1:0] r_num_right;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_left  <= NUM_RESET;
            r_num_right <= NUM_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_NUM_LEFT:  r_num_left  <= pwdata[FW-1:0];
                REG_NUM_RIGHT: r_num_right <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_LEFT:  prdata = 32'(r_num_left);
            REG_NUM_RIGHT: prdata = 32'(r_num_right);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.num_left  = r_num_left;
    assign o_cfg.num_right = r_num_right;
endmodule

`default_nettype wire

// ===== rtl/bmm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmm_engine
// adjacency, match and stack memories with the augmenting-path sequencer
// ---------------------------------------------------------------------------
module bmm_engine #(
    parameter int MAX_LEFT  = bmm_pkg::MAX_LEFT_DEF,
    parameter int MAX_RIGHT = bmm_pkg::MAX_RIGHT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  bmm_pkg::t_cfg i_cfg,
    bmm_in_if.sink       i_in,
    bmm_out_if.source    o_out
);
    import bmm_pkg::*;

    localparam int LW    = $clog2(MAX_LEFT + 1);
    localparam int AWL   = $clog2(MAX_LEFT);
    localparam int BW    = $clog2(MAX_RIGHT);
    localparam int VW    = $clog2(MAX_RIGHT + 2);
    localparam int MW    = $clog2(MAX_RIGHT + 1);
    localparam int DW    = $clog2(MAX_LEFT + 1);
    localparam int SW    = $clog2(MAX_LEFT);
    localparam int CLR_N = (MAX_LEFT > MAX_RIGHT + 1) ? MAX_LEFT : MAX_RIGHT + 1;
    localparam int CW    = $clog2(CLR_N);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROOT = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_MT   = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WWB  = 4'd6;
    localparam logic [3:0] S_POP  = 4'd7;
    localparam logic [3:0] S_CRD  = 4'd8;
    localparam logic [3:0] S_CCHK = 4'd9;
    localparam logic [3:0] S_OUTC = 4'd10;
    localparam logic [3:0] S_PRD  = 4'd11;
    localparam logic [3:0] S_PCHK = 4'd12;
    localparam logic [3:0] S_CLR  = 4'd13;

    // memories
    logic [MAX_RIGHT-1:0] mem_adj [MAX_LEFT];
    logic [LW-1:0]        mem_mt  [MAX_RIGHT+1];
    logic [LW+VW-1:0]     mem_stk [MAX_LEFT];

    logic [MAX_RIGHT-1:0] r_adj_q;
    logic [LW-1:0]        r_mt_q;
    logic [LW+VW-1:0]     r_stk_q;

    // sequencer state
    logic [3:0]           r_state;
    logic [LW-1:0]        r_nl;
    logic [VW-1:0]        r_nr;
    logic [LW-1:0]        r_root;
    logic [LW-1:0]        r_cu;
    logic [VW-1:0]        r_cv;
    logic [DW-1:0]        r_depth;
    logic [SW-1:0]        r_k;
    logic [MAX_RIGHT-1:0] r_seen;
    logic [VW-1:0]        r_v;
    logic [FW-1:0]        r_cnt;
    logic [FW-1:0]        r_n;
    logic [CW-1:0]        r_clr;

    // output register
    logic                 r_ov;
    logic                 r_o_is_count;
    logic [FW-1:0]        r_o_count;
    logic [FW-1:0]        r_o_left;
    logic [FW-1:0]        r_o_right;
    logic                 r_o_last;

    // memory controls
    logic                 adj_set, adj_clr, adj_rd;
    logic [AWL-1:0]       adj_waddr, adj_raddr;
    logic [BW-1:0]        adj_bidx;
    logic                 mt_we, mt_rd;
    logic [MW-1:0]        mt_waddr, mt_raddr;
    logic [LW-1:0]        mt_wdata;
    logic                 stk_we, stk_rd;
    logic [SW-1:0]        stk_waddr, stk_raddr;

    logic [MAX_RIGHT-1:0] cand;
    logic                 found;
    logic [VW-1:0]        found_v;
    logic                 edge_ok;
    logic                 in_fire;
    logic                 slot_free;
    logic                 out_load;
    logic [LW-1:0]        stk_left;
    logic [VW-1:0]        stk_right;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign slot_free  = !r_ov || o_out.ready;
    assign out_load   = slot_free && ((r_state == S_OUTC)
                                      || ((r_state == S_PCHK) && (r_mt_q != '0)));
    assign stk_left   = r_stk_q[LW+VW-1:VW];
    assign stk_right  = r_stk_q[VW-1:0];

    assign edge_ok = (int'(i_in.left_vertex) >= 1) && (int'(i_in.left_vertex) <= MAX_LEFT)
                  && (int'(i_in.right_vertex) >= 1) && (int'(i_in.right_vertex) <= MAX_RIGHT);

    // lowest unseen neighbor at or above the current right vertex
    always_comb begin
        for (int j = 0; j < MAX_RIGHT; j++) begin
            cand[j] = r_adj_q[j] && !r_seen[j] && (j + 1 >= int'(r_cv)) && (j < int'(r_nr));
        end
        found   = 1'b0;
        found_v = '0;
        for (int j = MAX_RIGHT - 1; j >= 0; j--) begin
            if (cand[j]) begin
                found   = 1'b1;
                found_v = VW'(j + 1);
            end
        end
    end

    always_comb begin
        adj_set   = 1'b0;
        adj_clr   = 1'b0;
        adj_rd    = 1'b0;
        adj_waddr = AWL'(int'(i_in.left_vertex) - 1);
        adj_bidx  = BW'(int'(i_in.right_vertex) - 1);
        adj_raddr = AWL'(int'(r_cu) - 1);
        mt_we     = 1'b0;
        mt_rd     = 1'b0;
        mt_waddr  = MW'(r_cv);
        mt_wdata  = r_cu;
        mt_raddr  = MW'(r_v);
        stk_we    = 1'b0;
        stk_rd    = 1'b0;
        stk_waddr = SW'(int'(r_depth) - 1);
        stk_raddr = r_k;
        case (r_state)
            S_IDLE: adj_set = in_fire && !i_in.kind && edge_ok;
            S_RD:   adj_rd = 1'b1;
            S_SCAN: begin
                if (found) begin
                    mt_rd    = 1'b1;
                    mt_raddr = MW'(found_v);
                end else if (r_depth > DW'(1)) begin
                    stk_rd    = 1'b1;
                    stk_raddr = SW'(int'(r_depth) - 2);
                end
            end
            S_MT: begin
                if (r_mt_q == '0) begin
                    mt_we = 1'b1;
                end else if (int'(r_depth) < MAX_LEFT) begin
                    stk_we = 1'b1;
                end
            end
            S_WRD:  stk_rd = 1'b1;
            S_WWB: begin
                mt_we    = 1'b1;
                mt_waddr = MW'(stk_right);
                mt_wdata = stk_left;
            end
            S_CRD, S_PRD: mt_rd = 1'b1;
            S_CLR: begin
                adj_clr   = (int'(r_clr) < MAX_LEFT);
                adj_waddr = AWL'(r_clr);
                mt_we     = (int'(r_clr) <= MAX_RIGHT);
                mt_waddr  = MW'(r_clr);
                mt_wdata  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adj_set) begin
            mem_adj[adj_waddr][adj_bidx] <= 1'b1;
        end
        if (adj_clr) begin
            mem_adj[adj_waddr] <= '0;
        end
        if (adj_rd) begin
            r_adj_q <= mem_adj[adj_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mt_we) begin
            mem_mt[mt_waddr] <= mt_wdata;
        end
        if (mt_rd) begin
            r_mt_q <= mem_mt[mt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_waddr] <= {r_cu, r_cv};
        end
        if (stk_rd) begin
            r_stk_q <= mem_stk[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (r_ov && o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_depth <= '0;
            r_seen  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire && i_in.kind) begin
                        r_nl   <= (int'(i_cfg.num_left) > MAX_LEFT) ? LW'(MAX_LEFT)
                                                                    : LW'(i_cfg.num_left);
                        r_nr   <= (int'(i_cfg.num_right) > MAX_RIGHT) ? VW'(MAX_RIGHT)
                                                                      : VW'(i_cfg.num_right);
                        r_root <= LW'(1);
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_nl == '0) begin
                        r_cnt <= '0;
                        r_v   <= VW'(1);
                        r_state <= (r_nr == '0) ? S_OUTC : S_CRD;
                    end else begin
                        r_seen  <= '0;
                        r_cu    <= r_root;
                        r_cv    <= VW'(1);
                        r_depth <= DW'(1);
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    if (found) begin
                        r_seen  <= r_seen | (MAX_RIGHT'(1) << (int'(found_v) - 1));
                        r_cv    <= found_v;
                        r_state <= S_MT;
                    end else begin
                        r_depth <= r_depth - DW'(1);
                        if (r_depth > DW'(1)) begin
                            r_state <= S_POP;
                        end else if (r_root == r_nl) begin
                            r_cnt <= '0;
                            r_v   <= VW'(1);
                            r_state <= (r_nr == '0) ? S_OUTC : S_CRD;
                        end else begin
                            r_root  <= r_root + LW'(1);
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_POP: begin
                    r_cu    <= stk_left;
                    r_cv    <= stk_right + VW'(1);
                    r_state <= S_RD;
                end
                S_MT: begin
                    if (r_mt_q == '0) begin
                        if (r_depth > DW'(1)) begin
                            r_k     <= '0;
                            r_state <= S_WRD;
                        end else if (r_root == r_nl) begin
                            r_cnt <= '0;
                            r_v   <= VW'(1);
                            r_state <= (r_nr == '0) ? S_OUTC : S_CRD;
                        end else begin
                            r_root  <= r_root + LW'(1);
                            r_state <= S_ROOT;
                        end
                    end else if (int'(r_depth) < MAX_LEFT) begin
                        r_cu    <= r_mt_q;
                        r_cv    <= VW'(1);
                        r_depth <= r_depth + DW'(1);
                        r_state <= S_RD;
                    end else begin
                        r_cv    <= r_cv + VW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_WRD: r_state <= S_WWB;
                S_WWB: begin
                    if (int'(r_k) == int'(r_depth) - 2) begin
                        if (r_root == r_nl) begin
                            r_cnt <= '0;
                            r_v   <= VW'(1);
                            r_state <= (r_nr == '0) ? S_OUTC : S_CRD;
                        end else begin
                            r_root  <= r_root + LW'(1);
                            r_state <= S_ROOT;
                        end
                    end else begin
                        r_k     <= r_k + SW'(1);
                        r_state <= S_WRD;
                    end
                end
                S_CRD: r_state <= S_CCHK;
                S_CCHK: begin
                    if (r_mt_q != '0) begin
                        r_cnt <= r_cnt + FW'(1);
                    end
                    if (r_v == r_nr) begin
                        r_state <= S_OUTC;
                    end else begin
                        r_v     <= r_v + VW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_OUTC: begin
                    if (slot_free) begin
                        r_o_is_count <= 1'b1;
                        r_o_count    <= r_cnt;
                        r_o_left     <= '0;
                        r_o_right    <= '0;
                        r_o_last     <= (r_cnt == '0);
                        r_v          <= VW'(1);
                        r_n          <= FW'(1);
                        r_clr        <= '0;
                        r_state      <= (r_cnt == '0) ? S_CLR : S_PRD;
                    end
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (r_mt_q == '0) begin
                        r_v     <= r_v + VW'(1);
                        r_state <= S_PRD;
                    end else if (slot_free) begin
                        r_o_is_count <= 1'b0;
                        r_o_count    <= '0;
                        r_o_left     <= FW'(r_mt_q);
                        r_o_right    <= FW'(r_v);
                        r_o_last     <= (r_n == r_cnt);
                        r_n          <= r_n + FW'(1);
                        r_v          <= r_v + VW'(1);
                        r_clr        <= '0;
                        r_state      <= (r_n == r_cnt) ? S_CLR : S_PRD;
                    end
                end
                S_CLR: begin
                    if (int'(r_clr) == CLR_N - 1) begin
                        r_depth <= '0;
                        r_seen  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + CW'(1);
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.is_count    = r_o_is_count;
    assign o_out.match_count = r_o_count;
    assign o_out.pair_left   = r_o_left;
    assign o_out.pair_right  = r_o_right;
    assign o_out.last        = r_o_last;
endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the bipartite matching block: edge and end
// transactions go in, a local augmenting-path matcher predicts the count
// and pair transactions, every result is checked field by field
// ---------------------------------------------------------------------------
module tb_top;
    import bmm_pkg::*;

    typedef struct packed {
        logic          is_count;
        logic [FW-1:0] match_count;
        logic [FW-1:0] pair_left;
        logic [FW-1:0] pair_right;
        logic          last;
    } t_match_res;

    typedef struct {
        logic          kind;
        logic [FW-1:0] lv;
        logic [FW-1:0] rv;
        int            typed_count;
    } t_row;

    localparam int NL = MAX_LEFT_DEF;
    localparam int NR = MAX_RIGHT_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmm_in_if  in_ch();
    bmm_out_if out_ch();

    bipartite_max_matching u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [NR-1:0] adj_rows [NL];
    logic [FW-1:0] owner_of [NR+1];
    logic [NR-1:0] seen_bits;
    logic [FW-1:0] cfg_left;
    logic [FW-1:0] cfg_right;

    t_match_res expected_results[$];
    int  fail_count;
    int  cycle_count;
    bit  stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit try_augment(int u, int nr);
        for (int v = 1; v <= nr; v++) begin
            if (adj_rows[u-1][v-1] && !seen_bits[v-1]) begin
                seen_bits[v-1] = 1'b1;
                if (owner_of[v] == 0 || try_augment(owner_of[v], nr)) begin
                    owner_of[v] = FW'(u);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_matching();
        int nl;
        int nr;
        int count;
        int n;
        t_match_res r;
        nl = (cfg_left > NL) ? NL : cfg_left;
        nr = (cfg_right > NR) ? NR : cfg_right;
        for (int u = 1; u <= nl; u++) begin
            seen_bits = '0;
            void'(try_augment(u, nr));
        end
        count = 0;
        for (int v = 1; v <= nr; v++) if (owner_of[v] != 0) count++;
        r = '0;
        r.is_count = 1'b1;
        r.match_count = FW'(count);
        r.last = (count == 0);
        expected_results.push_back(r);
        n = 0;
        for (int v = 1; v <= nr; v++) begin
            if (owner_of[v] != 0) begin
                n++;
                r = '0;
                r.pair_left = owner_of[v];
                r.pair_right = FW'(v);
                r.last = (n == count);
                expected_results.push_back(r);
            end
        end
        foreach (adj_rows[i]) adj_rows[i] = '0;
        foreach (owner_of[i]) owner_of[i] = '0;
    endtask

    task automatic apply_item(logic kind, logic [FW-1:0] lv, logic [FW-1:0] rv);
        if (kind == 1'b0) begin
            if (lv >= 1 && lv <= NL && rv >= 1 && rv <= NR) adj_rows[lv-1][rv-1] = 1'b1;
        end else begin
            predict_matching();
        end
    endtask

    task automatic send_item(logic kind, logic [FW-1:0] lv, logic [FW-1:0] rv);
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.left_vertex  <= lv;
        in_ch.right_vertex <= rv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        apply_item(kind, lv, rv);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [FW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_NUM_LEFT) ? 3'd0 : 3'd4;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NUM_LEFT) cfg_left = value;
        else cfg_right = value;
        @(posedge i_clk);
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_match_res got;
        t_match_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.is_count, out_ch.match_count, out_ch.pair_left,
                    out_ch.pair_right, out_ch.last};
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.is_count !== want.is_count) begin
                    $error("is_count expected %0d actual %0d", want.is_count, got.is_count);
                    fail_count++;
                end
                if (got.match_count !== want.match_count) begin
                    $error("match_count expected %0d actual %0d",
                           want.match_count, got.match_count);
                    fail_count++;
                end
                if (got.pair_left !== want.pair_left) begin
                    $error("pair_left expected %0d actual %0d", want.pair_left, got.pair_left);
                    fail_count++;
                end
                if (got.pair_right !== want.pair_right) begin
                    $error("pair_right expected %0d actual %0d",
                           want.pair_right, got.pair_right);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // sink backpressure in bursts
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic random_graph(int edges, int lmax, int rmax);
        for (int i = 0; i < edges; i++) begin
            send_item(1'b0, FW'($urandom_range(1, lmax)), FW'($urandom_range(1, rmax)));
        end
        send_item(1'b1, FW'($urandom), FW'($urandom));
    endtask

    initial begin
        t_row rows[$];
        t_match_res r;
        int sent;
        in_ch.valid        = 1'b0;
        in_ch.kind         = 1'b0;
        in_ch.left_vertex  = '0;
        in_ch.right_vertex = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        stall_enable = 1'b1;
        cfg_left = NUM_RESET;
        cfg_right = NUM_RESET;
        foreach (adj_rows[i]) adj_rows[i] = '0;
        foreach (owner_of[i]) owner_of[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty graph after reset, zero and out-of-range endpoints,
        // extremes, a contended chain and an edge beyond the registers
        rows = '{
            '{1'b1, 6'd0,  6'd0,  0},
            '{1'b0, 6'd0,  6'd5,  -1},
            '{1'b0, 6'd5,  6'd0,  -1},
            '{1'b0, 6'd33, 6'd1,  -1},
            '{1'b0, 6'd63, 6'd63, -1},
            '{1'b1, 6'd63, 6'd63, 0},
            '{1'b0, 6'd32, 6'd32, -1},
            '{1'b0, 6'd1,  6'd1,  -1},
            '{1'b0, 6'd2,  6'd1,  -1},
            '{1'b0, 6'd2,  6'd2,  -1},
            '{1'b0, 6'd3,  6'd2,  -1},
            '{1'b0, 6'd3,  6'd3,  -1},
            '{1'b0, 6'd4,  6'd1,  -1},
            '{1'b1, 6'd0,  6'd0,  -1}
        };
        foreach (rows[i]) begin
            if (rows[i].typed_count >= 0) begin
                r = '0;
                r.is_count = 1'b1;
                r.match_count = FW'(rows[i].typed_count);
                r.last = 1'b1;
                send_item(rows[i].kind, rows[i].lv, rows[i].rv);
                // replace the predicted entry with the typed one
                void'(expected_results.pop_back());
                expected_results.push_back(r);
            end else begin
                send_item(rows[i].kind, rows[i].lv, rows[i].rv);
            end
        end
        wait_drained();

        // register settings: minimum, zero, saturating, odd sizes
        write_reg(REG_NUM_LEFT, 6'd1);
        write_reg(REG_NUM_RIGHT, 6'd1);
        send_item(1'b0, 6'd1, 6'd1);
        send_item(1'b0, 6'd2, 6'd1);
        send_item(1'b1, 6'd0, 6'd0);
        wait_drained();
        write_reg(REG_NUM_LEFT, 6'd0);
        send_item(1'b0, 6'd1, 6'd1);
        send_item(1'b1, 6'd0, 6'd0);
        wait_drained();
        write_reg(REG_NUM_LEFT, 6'd63);
        write_reg(REG_NUM_RIGHT, 6'd63);
        for (int v = 1; v <= NR; v++) send_item(1'b0, FW'(v), FW'(NR + 1 - v));
        send_item(1'b1, 6'd0, 6'd0);
        wait_drained();

        // random graphs over several settings
        sent = 0;
        while (sent < 380) begin
            int lm;
            int rm;
            int ne;
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_reg(REG_NUM_LEFT, FW'($urandom_range(0, 40)));
                write_reg(REG_NUM_RIGHT, FW'($urandom_range(0, 40)));
            end
            if (sent > 310) stall_enable = 1'b0;
            lm = $urandom_range(2, 32);
            rm = $urandom_range(2, 32);
            ne = $urandom_range(0, 14);
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'b0, FW'($urandom), FW'($urandom));
                sent++;
            end
            random_graph(ne, lm, rm);
            sent += ne + 1;
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== bipartite_max_matching.f =====
rtl/bmm_pkg.sv
rtl/bmm_in_if.sv
rtl/bmm_out_if.sv
rtl/bmm_cfg.sv
rtl/bmm_engine.sv
rtl/bipartite_max_matching.sv
verif/tb_top.sv
